/* design/tccc_pkg.sv */
// ----------------------------------------------------------------------------
// tccc_pkg: shared types and constants of the text console cursor control
// Field layouts, register indexes, reset values and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tccc_pkg;

  // Spaces that one tab expands into, and the tab phase counter
  localparam int TAB_SPACES = 4;
  localparam int PHASE_W    = $clog2(TAB_SPACES + 1);
  typedef logic [PHASE_W-1:0] phase_t;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_CELL_WIDTH    = 3'd2,
    REG_CELL_HEIGHT   = 3'd3,
    REG_LINE_END_X    = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd1024;
  localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd768;
  localparam logic [7:0]  RST_CELL_WIDTH    = 8'd8;
  localparam logic [7:0]  RST_CELL_HEIGHT   = 8'd16;
  localparam logic [15:0] RST_LINE_END_X    = 16'd1024;

  // Character codes and the blank colour
  localparam logic [7:0]  CH_BS       = 8'd8;
  localparam logic [7:0]  CH_TAB      = 8'd9;
  localparam logic [7:0]  CH_NL       = 8'd10;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [31:0] BLANK_COLOR = 32'hFF00_0000;

  // Stream widths
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 104;
  localparam int M_TUSER_W = 3;

  typedef struct packed {
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic [7:0]  cell_width;
    logic [7:0]  cell_height;
    logic [15:0] line_end_x;
  } cfg_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } cursor_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [31:0] letter_color;
    logic [31:0] highlight_color;
  } item_t;

  typedef struct packed {
    logic        draw_valid;
    logic [7:0]  glyph;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic        clear_screen;
    logic        accepted;
    logic        last;
  } result_t;

  // Step status: a result is produced, the request is finished
  typedef struct packed {
    logic emit;
    logic done;
  } step_ctl_t;

endpackage

`default_nettype wire

/* design/tccc_cfg.sv */
// ----------------------------------------------------------------------------
// tccc_cfg: configuration register file
// Holds screen and cell geometry; written by index, no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tccc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tccc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tccc_pkg::cfg_t                        cfg
);
  import tccc_pkg::*;

  // Load the addressed register, ignore indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RST_SCREEN_WIDTH;
      cfg.screen_height <= RST_SCREEN_HEIGHT;
      cfg.cell_width    <= RST_CELL_WIDTH;
      cfg.cell_height   <= RST_CELL_HEIGHT;
      cfg.line_end_x    <= RST_LINE_END_X;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        REG_CELL_WIDTH:    cfg.cell_width    <= cfg_data[7:0];
        REG_CELL_HEIGHT:   cfg.cell_height   <= cfg_data[7:0];
        REG_LINE_END_X:    cfg.line_end_x    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/tccc_step.sv */
// ----------------------------------------------------------------------------
// tccc_step: one cursor step
// Computes the result and the next cursor for the held request and phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_step (
  input  wire tccc_pkg::cfg_t      cfg,
  input  wire tccc_pkg::cursor_t   cursor,
  input  wire tccc_pkg::item_t     item,
  input  wire tccc_pkg::phase_t    phase,
  output tccc_pkg::result_t        res,
  output tccc_pkg::cursor_t        cursor_next,
  output tccc_pkg::step_ctl_t      ctl
);
  import tccc_pkg::*;

  logic        is_nl;
  logic        x_over, y_full, need, refuse;
  logic [15:0] wx, wy, dx;
  logic        la_over, la_full, next_ref;
  logic [15:0] bs_x0, bs_x, bs_y;
  logic        space_last;

  // Wrap check at the current cursor
  always_comb begin
    is_nl  = (item.char_code == CH_NL);
    x_over = ({1'b0, cursor.x} + {9'd0, cfg.cell_width}) > {1'b0, cfg.screen_width};
    y_full = ({1'b0, cursor.y} + {8'd0, cfg.cell_height, 1'b0})
             > {1'b0, cfg.screen_height};
    need   = x_over || is_nl;
    refuse = need && y_full;
    wx     = need ? 16'd0 : cursor.x;
    wy     = need ? cursor.y + {8'd0, cfg.cell_height} : cursor.y;
    dx     = wx + {8'd0, cfg.cell_width};
  end

  // Look ahead: would the next tab space be refused after this draw
  always_comb begin
    la_over  = ({1'b0, dx} + {9'd0, cfg.cell_width}) > {1'b0, cfg.screen_width};
    la_full  = ({1'b0, wy} + {8'd0, cfg.cell_height, 1'b0})
               > {1'b0, cfg.screen_height};
    next_ref = la_over && la_full;
  end

  // Backspace target, saturating at zero
  always_comb begin
    bs_y  = (cursor.x != 16'd0) ? cursor.y :
            (cursor.y > {8'd0, cfg.cell_height}) ?
            cursor.y - {8'd0, cfg.cell_height} : 16'd0;
    bs_x0 = (cursor.x == 16'd0) ? cfg.line_end_x : cursor.x;
    bs_x  = (bs_x0 > {8'd0, cfg.cell_width}) ? bs_x0 - {8'd0, cfg.cell_width} : 16'd0;
  end

  assign space_last = (phase == PHASE_W'(TAB_SPACES)) || next_ref;

  // Select the action for this request
  always_comb begin
    res          = '0;
    res.accepted = 1'b1;
    res.last     = 1'b1;
    cursor_next  = cursor;
    ctl.emit     = 1'b1;
    ctl.done     = 1'b1;
    priority if (item.mode) begin
      cursor_next.x    = 16'd0;
      cursor_next.y    = {8'd0, cfg.cell_height};
      res.clear_screen = 1'b1;
    end else if (item.char_code == CH_BS) begin
      if (!(cursor.x == 16'd0 && cursor.y == 16'd0)) begin
        cursor_next.x  = bs_x;
        cursor_next.y  = bs_y;
        res.draw_valid = 1'b1;
        res.pos_x      = bs_x;
        res.pos_y      = bs_y;
        res.fg_color   = BLANK_COLOR;
        res.bg_color   = BLANK_COLOR;
      end
    end else if (item.char_code == CH_TAB) begin
      if (phase == '0) begin
        // Tab itself: refuse, or move silently and go on to the spaces
        if (refuse) begin
          res.accepted = 1'b0;
        end else begin
          cursor_next.x = wx;
          cursor_next.y = wy;
          ctl.emit      = 1'b0;
          ctl.done      = 1'b0;
        end
      end else if (!refuse) begin
        cursor_next.x  = dx;
        cursor_next.y  = wy;
        res.draw_valid = 1'b1;
        res.glyph      = CH_SPACE;
        res.pos_x      = wx;
        res.pos_y      = wy;
        res.fg_color   = item.letter_color;
        res.bg_color   = item.highlight_color;
        res.last       = space_last;
        ctl.done       = space_last;
      end
    end else if (refuse) begin
      res.accepted = 1'b0;
    end else if (is_nl) begin
      cursor_next.x = wx;
      cursor_next.y = wy;
    end else begin
      cursor_next.x  = dx;
      cursor_next.y  = wy;
      res.draw_valid = 1'b1;
      res.glyph      = item.char_code;
      res.pos_x      = wx;
      res.pos_y      = wy;
      res.fg_color   = item.letter_color;
      res.bg_color   = item.highlight_color;
    end
  end

endmodule

`default_nettype wire

/* design/text_console_cursor_control.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_control: pixel cursor for a glyph-cell text console
// Turns characters into glyph draw commands and tracks the cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one request per transfer, mode in s_tuser, character
//   and colours in s_tdata. Output stream m_*: one or more results per
//   request, m_tlast on the final one; flags in m_tuser.
//   Geometry registers are written through cfg_we/cfg_index/cfg_data while
//   no request is in flight.
//   A request is captured in the input register; its result goes through
//   the step unit into the output register once that register has room,
//   and the output register drives m_tvalid.
//   Throughput: one request per cycle for every character but a tab, while
//   m_tready does not stall. A tab holds the step unit for a positioning
//   step and one step per drawn space, up to TAB_SPACES spaces, as each step
//   reads and writes the single cursor register.
//   Reset clears both stream registers, homes the cursor to x 0, y 16 and
//   loads the register defaults.
//   A stalled m_tready holds the output result; the held request waits and
//   s_tready drops until the output register can take the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_control (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata: char_code[7:0], letter_color[39:8], highlight_color[71:40]
  input  wire logic [tccc_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: mode[0]
  input  wire logic [0:0]                       s_tuser,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // m_tdata: glyph[7:0], pos_x[23:8], pos_y[39:24], fg_color[71:40],
  //          bg_color[103:72]
  output logic [tccc_pkg::M_TDATA_W-1:0]        m_tdata,
  // m_tuser: draw_valid[0], clear_screen[1], accepted[2]
  output logic [tccc_pkg::M_TUSER_W-1:0]        m_tuser,
  output logic                                  m_tlast,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_we,
  input  wire logic [tccc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tccc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tccc_pkg::*;

  cfg_t      cfg;
  item_t     in_item;
  item_t     hold;
  logic      hold_valid;
  phase_t    phase;
  cursor_t   cursor;
  cursor_t   cursor_next;
  result_t   step_res;
  step_ctl_t step_ctl;
  result_t   out_res;
  logic      out_valid;
  logic      out_free;
  logic      commit;
  logic      s_accept;

  tccc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tccc_step u_step (
    .cfg         (cfg),
    .cursor      (cursor),
    .item        (hold),
    .phase       (phase),
    .res         (step_res),
    .cursor_next (cursor_next),
    .ctl         (step_ctl)
  );

  // Unpack the input request
  always_comb begin
    in_item.mode            = s_tuser[0];
    in_item.char_code       = s_tdata[7:0];
    in_item.letter_color    = s_tdata[39:8];
    in_item.highlight_color = s_tdata[71:40];
  end

  // Advance the step when its result, if any, has room
  assign out_free = !out_valid || m_tready;
  assign commit   = hold_valid && (!step_ctl.emit || out_free);
  assign s_tready = !hold_valid || (commit && step_ctl.done);
  assign s_accept = s_tvalid && s_tready;

  // Input register control and tab phase
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= '0;
    end else if (s_accept) begin
      hold_valid <= 1'b1;
      phase      <= '0;
    end else if (commit && step_ctl.done) begin
      hold_valid <= 1'b0;
      phase      <= '0;
    end else if (commit) begin
      phase      <= phase + PHASE_W'(1);
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      hold <= in_item;
    end
  end

  // Cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor.x <= 16'd0;
      cursor.y <= {8'd0, RST_CELL_HEIGHT};
    end else if (commit) begin
      cursor <= cursor_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && step_ctl.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (commit && step_ctl.emit) begin
      out_res <= step_res;
    end
  end

  // Pack the result
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.bg_color, out_res.fg_color, out_res.pos_y,
                     out_res.pos_x, out_res.glyph};
  assign m_tuser  = {out_res.accepted, out_res.clear_screen, out_res.draw_valid};
  assign m_tlast  = out_res.last;

endmodule

`default_nettype wire

/* design/tccc_checker.sv */
// ----------------------------------------------------------------------------
// tccc_checker: port-level checks of the text console cursor control
// Watches the result stream and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic [tccc_pkg::M_TDATA_W-1:0]   m_tdata,
  input wire logic [tccc_pkg::M_TUSER_W-1:0]   m_tuser,
  input wire logic                             m_tlast,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready
);
  import tccc_pkg::*;

  // Output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A result without a draw carries an all-zero payload
  a_nodraw_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("non-draw result carries payload");

  // A home result or a refusal is the single, non-drawing result of its request
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1] || !m_tuser[2]) |-> m_tlast && !m_tuser[0])
    else $error("home or refusal result is not a lone non-draw result");

endmodule

bind text_console_cursor_control tccc_checker u_tccc_checker (.*);

`default_nettype wire
